FILE: sv/bsp_pkg.sv
// ----------------------------------------------------------------------------
// bsp_pkg: shared types and constants of the bounded sorted process list
//
// Holds the command and result payload structs, the stored entry layout,
// and the action, status and register codes.
// ----------------------------------------------------------------------------
package bsp_pkg;

    localparam int HANDLE_BITS = 8;
    localparam int KEY_BITS    = 16;
    localparam int COUNT_BITS  = 5;
    localparam int ACTION_BITS = 2;
    localparam int STATUS_BITS = 2;
    localparam int ENTRY_BITS  = HANDLE_BITS + KEY_BITS;

    // Action codes
    localparam logic [ACTION_BITS-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_DELETE = 2'd2;

    // Status codes
    localparam logic [STATUS_BITS-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_MISSING = 2'd2;

    // Register indexes
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic [COUNT_BITS-1:0] CAPACITY_RESET = 5'd16;

    typedef struct packed {
        logic [ACTION_BITS-1:0] action;
        logic [HANDLE_BITS-1:0] entry_handle;
        logic [KEY_BITS-1:0]    sort_key;
    } t_cmd;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [COUNT_BITS-1:0]  entry_count;
        logic                   list_empty;
        logic [HANDLE_BITS-1:0] head_handle;
        logic [KEY_BITS-1:0]    head_key;
    } t_result;

    typedef struct packed {
        logic [HANDLE_BITS-1:0] handle;
        logic [KEY_BITS-1:0]    key;
    } t_entry;

endpackage

FILE: sv/bsp_ram.sv
// ----------------------------------------------------------------------------
// bsp_ram: generic simple dual-port RAM
//
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module bsp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/bounded_sorted_process_list.sv
// ----------------------------------------------------------------------------
// bounded_sorted_process_list: bounded ordered list of process entries
//
// Usage: drive i_cmd and raise start while busy is low; the command is taken
// at that edge and busy stays high until the result is out. Actions are
// append at tail, ordered insert by key (before the first larger key) and
// delete of the first entry with a matching handle.
// Each command yields exactly one result: o_strobe is high for one cycle with
// o_result (status, count, empty flag, head entry). The receiver cannot stall.
// After the accept edge, append and ordered insert into an empty list pass
// S_TAIL, S_HEAD and S_DONE before o_strobe; refused commands, delete on an
// empty list and the unused action code pass S_HEAD and S_DONE only; ordered
// insert first walks the stored entries in S_INS and delete in S_DEL. The
// sequencer does one RAM read and at most one write per cycle, walking the
// list from the head. A new command may be started in the cycle the strobe
// is shown. Configuration: APB register 0 (byte 0) holds capacity_limit, to
// be written by the user only while the block is idle; the block does not
// enforce this. Reset clears the list count and sets capacity to 16; stored
// slots are not cleared since only slots below the count are read.
// ----------------------------------------------------------------------------
module bounded_sorted_process_list #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  bsp_pkg::t_cmd      i_cmd,
    output logic               o_strobe,
    output bsp_pkg::t_result   o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = $clog2(MAX_ENTRIES);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_INS  = 6'b000010,
        S_TAIL = 6'b000100,
        S_DEL  = 6'b001000,
        S_HEAD = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state                                r_state, n_state;
    logic [bsp_pkg::COUNT_BITS-1:0]        r_fill, n_fill;
    logic [bsp_pkg::COUNT_BITS-1:0]        r_cap;
    logic [AW-1:0]                         r_idx, n_idx;
    bsp_pkg::t_entry                       r_carry, n_carry;
    bsp_pkg::t_entry                       r_item, n_item;
    logic                                  r_hit, n_hit;
    logic [bsp_pkg::STATUS_BITS-1:0]       r_status, n_status;
    logic                                  r_strobe;
    bsp_pkg::t_result                      r_result;

    logic                                  ram_we;
    logic [AW-1:0]                         ram_waddr;
    bsp_pkg::t_entry                       ram_wdata;
    logic [AW-1:0]                         ram_raddr;
    bsp_pkg::t_entry                       rd_entry;
    logic [bsp_pkg::ENTRY_BITS-1:0]        rd_word;

    logic                                  accept;
    logic                                  full;
    logic                                  last;
    logic                                  hit_now;
    logic                                  cfg_write;

    bsp_ram #(
        .WIDTH (bsp_pkg::ENTRY_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_word)
    );

    assign rd_entry = rd_word;
    assign accept   = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);
    assign full     = (32'(r_fill) >= MAX_ENTRIES) || (r_fill >= r_cap);
    assign last     = ((32'(r_idx) + 32'd1) == 32'(r_fill));

    // Sequencer: walk the list once from the head, one slot per cycle
    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_idx     = r_idx;
        n_carry   = r_carry;
        n_item    = r_item;
        n_hit     = r_hit;
        n_status  = r_status;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = r_carry;
        ram_raddr = '0;
        hit_now   = 1'b0;

        case (r_state)
            S_IDLE: begin
                // Slot 0 is read here so its data is ready in the first scan cycle
                if (accept) begin
                    n_item.handle = i_cmd.entry_handle;
                    n_item.key    = i_cmd.sort_key;
                    n_carry       = n_item;
                    n_idx         = '0;
                    n_hit         = 1'b0;
                    n_status      = bsp_pkg::ST_DONE;
                    if (i_cmd.action == bsp_pkg::ACT_APPEND ||
                        i_cmd.action == bsp_pkg::ACT_INSERT) begin
                        if (full) begin
                            n_status = bsp_pkg::ST_FULL;
                            n_state  = S_HEAD;
                        end else if (i_cmd.action == bsp_pkg::ACT_INSERT &&
                                     r_fill != '0) begin
                            n_state = S_INS;
                        end else begin
                            n_state = S_TAIL;
                        end
                    end else if (i_cmd.action == bsp_pkg::ACT_DELETE) begin
                        if (r_fill == '0) begin
                            n_status = bsp_pkg::ST_MISSING;
                            n_state  = S_HEAD;
                        end else begin
                            n_state = S_DEL;
                        end
                    end else begin
                        n_state = S_HEAD;
                    end
                end
            end
            S_INS: begin
                // Once a larger key is seen, write the carried entry and carry the old one
                ram_raddr = AW'(32'(r_idx) + 32'd1);
                hit_now   = r_hit || (rd_entry.key > r_item.key);
                if (hit_now) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_idx;
                    ram_wdata = r_carry;
                    n_carry   = rd_entry;
                    n_hit     = 1'b1;
                end
                n_idx = AW'(32'(r_idx) + 32'd1);
                if (last) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                // Write the carried entry one past the old tail
                ram_we    = 1'b1;
                ram_waddr = AW'(r_fill);
                ram_wdata = r_carry;
                n_fill    = r_fill + 1'b1;
                n_state   = S_HEAD;
            end
            S_DEL: begin
                // After the match, move each later entry down by one slot
                ram_raddr = AW'(32'(r_idx) + 32'd1);
                hit_now   = r_hit || (rd_entry.handle == r_item.handle);
                if (r_hit) begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(32'(r_idx) - 32'd1);
                    ram_wdata = rd_entry;
                end
                n_hit = hit_now;
                n_idx = AW'(32'(r_idx) + 32'd1);
                if (last) begin
                    if (hit_now) begin
                        n_fill = r_fill - 1'b1;
                    end else begin
                        n_status = bsp_pkg::ST_MISSING;
                    end
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                // Fetch the head entry after all writes have landed
                ram_raddr = '0;
                n_state   = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_strobe <= (r_state == S_DONE);
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_carry  <= n_carry;
        r_item   <= n_item;
        r_hit    <= n_hit;
        r_status <= n_status;
    end

    // Build the result from the head read
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE) begin
            r_result.status      <= r_status;
            r_result.entry_count <= r_fill;
            r_result.list_empty  <= (r_fill == '0);
            r_result.head_handle <= (r_fill == '0) ? '0 : rd_entry.handle;
            r_result.head_key    <= (r_fill == '0) ? '0 : rd_entry.key;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // Configuration register
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= bsp_pkg::CAPACITY_RESET;
        end else if (cfg_write && paddr[2] == bsp_pkg::REG_CAPACITY) begin
            r_cap <= pwdata[bsp_pkg::COUNT_BITS-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == bsp_pkg::REG_CAPACITY) ?
                    {{(32-bsp_pkg::COUNT_BITS){1'b0}}, r_cap} : 32'd0;

endmodule
